// ===== rtl/lrw_pkg.sv =====
`default_nettype none

package lrw_pkg;

    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;
    localparam int DRAW_BITS = 16;

    localparam int COL_BITS  = $clog2(MAX_COLS);
    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int SIZE_BITS = 7;
    localparam int PROB_BITS = 16;
    localparam int CNT_BITS  = 16;
    localparam int SUM_BITS  = PROB_BITS + 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [SIZE_BITS-1:0] MAX_COLS_S = SIZE_BITS'(MAX_COLS);
    localparam logic [SIZE_BITS-1:0] MAX_ROWS_S = SIZE_BITS'(MAX_ROWS);

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_STEP  = 2'd1,
        KIND_MAP   = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_WALKING = 2'd0,
        ST_GOAL    = 2'd1,
        ST_LIMIT   = 2'd2,
        ST_MAPDONE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CFG_GRID_WIDTH  = 3'd0,
        CFG_GRID_HEIGHT = 3'd1,
        CFG_PROB_UP     = 3'd2,
        CFG_PROB_DOWN   = 3'd3,
        CFG_PROB_LEFT   = 3'd4,
        CFG_PROB_RIGHT  = 3'd5,
        CFG_STEP_LIMIT  = 3'd6,
        CFG_UNUSED      = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        DIR_UP,
        DIR_DOWN,
        DIR_LEFT,
        DIR_RIGHT,
        DIR_STAY
    } dir_t;

    // zero acts as one, anything past the map acts as the map size
    function automatic logic [SIZE_BITS-1:0] size_in_use(
        input logic [SIZE_BITS-1:0] reg_val,
        input logic [SIZE_BITS-1:0] most
    );
        logic [SIZE_BITS-1:0] res;
        if (reg_val == '0)
            res = SIZE_BITS'(1);
        else if (reg_val > most)
            res = most;
        else
            res = reg_val;
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lrw_if.sv =====
`default_nettype none

interface lrw_item_if
    import lrw_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [COL_BITS-1:0]  cell_x;
    logic [ROW_BITS-1:0]  cell_y;
    logic [DRAW_BITS-1:0] draw;
    logic                 blocked_bit;

    modport source (output valid, kind, cell_x, cell_y, draw, blocked_bit, input ready);
    modport sink   (input valid, kind, cell_x, cell_y, draw, blocked_bit, output ready);
endinterface

interface lrw_result_if
    import lrw_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [COL_BITS-1:0] pos_x;
    logic [ROW_BITS-1:0] pos_y;
    logic [CNT_BITS-1:0] steps_taken;
    logic [1:0]          walk_status;
    logic                move_refused;

    modport source (output valid, pos_x, pos_y, steps_taken, walk_status, move_refused,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, steps_taken, walk_status, move_refused,
                    output ready);
endinterface

interface lrw_cfg_if
    import lrw_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lattice_random_walk_step.sv =====
// Random walker on a wrapping grid with an obstacle bit map.
// Channels: item (sink) takes start, step and map-write words; result (source)
// returns one word per item, in order; cfg (sink) writes the seven registers
// and is always ready. Cfg is only to be written while no item is in flight:
// that binds the user, and the block itself does not enforce it.
// Path: an accepted item passes through the input register, the second stage
// and the result register; an item taken while the one before it still waits
// for its position update stays in the input register until the second stage
// is free. Items do not overlap there: a step needs the walker position left
// by the previous item and then one read of the obstacle row memory.
// Reset: walker at (0,0), count 0, status walking, registers at their defaults.
// After reset the obstacle memory is cleared one row a cycle, all 64 rows, and
// item ready stays low for that pass; cfg writes are taken during it.
// Stall: while the result word waits, the stage just before the result
// register and the input register still fill, two more words in all; then
// item ready drops until the result is taken.
`default_nettype none

module lattice_random_walk_step
    import lrw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    lrw_item_if.sink      item,
    lrw_result_if.source  result,
    lrw_cfg_if.sink       cfg
);

    // configuration
    logic [SIZE_BITS-1:0] grid_width_reg, grid_height_reg;
    logic [PROB_BITS-1:0] prob_up_reg, prob_down_reg, prob_left_reg, prob_right_reg;
    logic [CNT_BITS-1:0]  step_limit_reg;

    // values derived from configuration
    logic [SIZE_BITS-1:0] w_reg, h_reg;
    logic [SUM_BITS-1:0]  sum_u_reg, sum_d_reg, sum_l_reg, sum_r_reg;

    // walker state
    logic [COL_BITS-1:0] walker_col_reg, walker_col_next;
    logic [ROW_BITS-1:0] walker_row_reg, walker_row_next;
    logic [CNT_BITS-1:0] step_cnt_reg, step_cnt_next;
    status_t             finish_reg, finish_next;

    // input register
    logic                 in_valid_reg;
    kind_t                in_kind_reg;
    logic [COL_BITS-1:0]  in_x_reg;
    logic [ROW_BITS-1:0]  in_y_reg;
    logic [DRAW_BITS-1:0] in_draw_reg;
    logic                 in_bit_reg;

    // second stage
    logic                s2_valid_reg;
    kind_t               s2_kind_reg;
    logic [COL_BITS-1:0] s2_x_reg;
    logic [ROW_BITS-1:0] s2_y_reg;
    logic [MAX_COLS-1:0] row_data_reg;

    // result register
    logic                out_valid_reg;
    logic [COL_BITS-1:0] out_x_reg, out_x_next;
    logic [ROW_BITS-1:0] out_y_reg, out_y_next;
    logic [CNT_BITS-1:0] out_cnt_reg, out_cnt_next;
    status_t             out_status_reg, out_status_next;
    logic                out_refused_reg, out_refused_next;

    // clear pass
    logic [ROW_BITS:0] clr_cnt_reg;
    logic              clearing;

    logic [MAX_COLS-1:0] obst_mem [MAX_ROWS];

    logic fire1, done2;

    // stage one candidate
    dir_t                 dir;
    logic [SUM_BITS-1:0]  draw_ext;
    logic [SIZE_BITS-1:0] col_ext, row_ext, x_raw, y_raw, x_wrap, y_wrap;
    logic [SIZE_BITS-1:0] cx_ext, cy_ext;
    logic [COL_BITS-1:0]  cand_x;
    logic [ROW_BITS-1:0]  cand_y;

    logic blocked;

    assign clearing = !clr_cnt_reg[ROW_BITS];
    assign fire1    = in_valid_reg && !s2_valid_reg;
    assign done2    = s2_valid_reg && (!out_valid_reg || result.ready);

    assign item.ready = !clearing && (!in_valid_reg || fire1);
    assign cfg.ready  = 1'b1;

    assign result.valid        = out_valid_reg;
    assign result.pos_x        = out_x_reg;
    assign result.pos_y        = out_y_reg;
    assign result.steps_taken  = out_cnt_reg;
    assign result.walk_status  = out_status_reg;
    assign result.move_refused = out_refused_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= MAX_COLS_S;
            grid_height_reg <= MAX_ROWS_S;
            prob_up_reg     <= PROB_BITS'(16384);
            prob_down_reg   <= PROB_BITS'(16384);
            prob_left_reg   <= PROB_BITS'(16384);
            prob_right_reg  <= PROB_BITS'(16384);
            step_limit_reg  <= CNT_BITS'(1000);
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg.data[SIZE_BITS-1:0];
                CFG_GRID_HEIGHT: grid_height_reg <= cfg.data[SIZE_BITS-1:0];
                CFG_PROB_UP:     prob_up_reg     <= cfg.data[PROB_BITS-1:0];
                CFG_PROB_DOWN:   prob_down_reg   <= cfg.data[PROB_BITS-1:0];
                CFG_PROB_LEFT:   prob_left_reg   <= cfg.data[PROB_BITS-1:0];
                CFG_PROB_RIGHT:  prob_right_reg  <= cfg.data[PROB_BITS-1:0];
                CFG_STEP_LIMIT:  step_limit_reg  <= cfg.data[CNT_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // settle sizes and running sums in registers fed by the configuration registers
    always_ff @(posedge clk)
    begin
        w_reg     <= size_in_use(grid_width_reg, MAX_COLS_S);
        h_reg     <= size_in_use(grid_height_reg, MAX_ROWS_S);
        sum_u_reg <= SUM_BITS'(prob_up_reg);
        sum_d_reg <= SUM_BITS'(prob_up_reg) + SUM_BITS'(prob_down_reg);
        sum_l_reg <= SUM_BITS'(prob_up_reg) + SUM_BITS'(prob_down_reg)
                   + SUM_BITS'(prob_left_reg);
        sum_r_reg <= SUM_BITS'(prob_up_reg) + SUM_BITS'(prob_down_reg)
                   + SUM_BITS'(prob_left_reg) + SUM_BITS'(prob_right_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            in_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            walker_col_reg <= '0;
            walker_row_reg <= '0;
            step_cnt_reg   <= '0;
            finish_reg     <= ST_WALKING;
        end
        else
        begin
            if (clearing)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;

            if (item.valid && item.ready)
                in_valid_reg <= 1'b1;
            else if (fire1)
                in_valid_reg <= 1'b0;

            if (fire1)
                s2_valid_reg <= 1'b1;
            else if (done2)
                s2_valid_reg <= 1'b0;

            if (done2)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            walker_col_reg <= walker_col_next;
            walker_row_reg <= walker_row_next;
            step_cnt_reg   <= step_cnt_next;
            finish_reg     <= finish_next;
        end
    end

    // input word
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_kind_reg <= kind_t'(item.kind);
            in_x_reg    <= item.cell_x;
            in_y_reg    <= item.cell_y;
            in_draw_reg <= item.draw;
            in_bit_reg  <= item.blocked_bit;
        end
    end

    // stage one: pick direction, wrap or clamp a start cell, address the obstacle row
    always_comb
    begin
        draw_ext = SUM_BITS'(in_draw_reg);
        if (draw_ext < sum_u_reg)
            dir = DIR_UP;
        else if (draw_ext < sum_d_reg)
            dir = DIR_DOWN;
        else if (draw_ext < sum_l_reg)
            dir = DIR_LEFT;
        else if (draw_ext < sum_r_reg)
            dir = DIR_RIGHT;
        else
            dir = DIR_STAY;

        col_ext = SIZE_BITS'(walker_col_reg);
        row_ext = SIZE_BITS'(walker_row_reg);
        x_raw   = col_ext;
        y_raw   = row_ext;
        case (dir)
            DIR_UP:    y_raw = (row_ext == '0) ? h_reg - 1'b1 : row_ext - 1'b1;
            DIR_DOWN:  y_raw = row_ext + 1'b1;
            DIR_LEFT:  x_raw = (col_ext == '0) ? w_reg - 1'b1 : col_ext - 1'b1;
            DIR_RIGHT: x_raw = col_ext + 1'b1;
            default:   ;
        endcase
        x_wrap = (x_raw >= w_reg) ? '0 : x_raw;
        y_wrap = (y_raw >= h_reg) ? '0 : y_raw;

        cx_ext = SIZE_BITS'(in_x_reg);
        cy_ext = SIZE_BITS'(in_y_reg);
        if (in_kind_reg == KIND_START)
        begin
            cand_x = (cx_ext < w_reg) ? in_x_reg : COL_BITS'(w_reg - 1'b1);
            cand_y = (cy_ext < h_reg) ? in_y_reg : ROW_BITS'(h_reg - 1'b1);
        end
        else
        begin
            cand_x = x_wrap[COL_BITS-1:0];
            cand_y = y_wrap[ROW_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire1)
        begin
            s2_kind_reg <= in_kind_reg;
            s2_x_reg    <= cand_x;
            s2_y_reg    <= cand_y;
        end
    end

    // obstacle rows: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (clearing)
            obst_mem[clr_cnt_reg[ROW_BITS-1:0]] <= '0;
        else if (fire1 && in_kind_reg == KIND_MAP)
            obst_mem[in_y_reg][in_x_reg] <= in_bit_reg;
        if (fire1)
            row_data_reg <= obst_mem[cand_y];
    end

    // stage two: settle a start, step or map write and build the result word
    always_comb
    begin
        blocked          = row_data_reg[s2_x_reg];
        walker_col_next  = walker_col_reg;
        walker_row_next  = walker_row_reg;
        step_cnt_next    = step_cnt_reg;
        finish_next      = finish_reg;
        out_refused_next = 1'b0;
        out_status_next  = finish_reg;

        if (done2)
        begin
            case (s2_kind_reg)
                KIND_START:
                begin
                    walker_col_next = s2_x_reg;
                    walker_row_next = s2_y_reg;
                    step_cnt_next   = '0;
                    finish_next     = (step_limit_reg == '0) ? ST_LIMIT : ST_WALKING;
                    out_status_next = finish_next;
                end
                KIND_STEP:
                begin
                    if (finish_reg == ST_WALKING)
                    begin
                        if (step_cnt_reg >= step_limit_reg)
                            finish_next = ST_LIMIT;
                        else
                        begin
                            if (blocked)
                                out_refused_next = 1'b1;
                            else
                            begin
                                walker_col_next = s2_x_reg;
                                walker_row_next = s2_y_reg;
                            end
                            step_cnt_next = step_cnt_reg + 1'b1;
                            if (SIZE_BITS'(walker_col_next) == SIZE_BITS'(w_reg[SIZE_BITS-1:1])
                                && SIZE_BITS'(walker_row_next)
                                   == SIZE_BITS'(h_reg[SIZE_BITS-1:1]))
                                finish_next = ST_GOAL;
                            else if (step_cnt_next >= step_limit_reg)
                                finish_next = ST_LIMIT;
                        end
                    end
                    out_status_next = finish_next;
                end
                KIND_MAP:
                    out_status_next = ST_MAPDONE;
                default:
                    out_status_next = finish_reg;
            endcase
        end

        out_x_next   = walker_col_next;
        out_y_next   = walker_row_next;
        out_cnt_next = step_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (done2)
        begin
            out_x_reg       <= out_x_next;
            out_y_reg       <= out_y_next;
            out_cnt_reg     <= out_cnt_next;
            out_status_reg  <= out_status_next;
            out_refused_reg <= out_refused_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lrw_checker.sv =====
`default_nettype none

module lrw_checker
    import lrw_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                res_valid,
    input wire logic                res_ready,
    input wire logic [COL_BITS-1:0] res_x,
    input wire logic [ROW_BITS-1:0] res_y,
    input wire logic [CNT_BITS-1:0] res_cnt,
    input wire logic [1:0]          res_status,
    input wire logic                res_refused
);

    logic [COL_BITS-1:0] prev_x_reg;
    logic [ROW_BITS-1:0] prev_y_reg;
    logic [CNT_BITS-1:0] prev_cnt_reg;
    logic                res_take;

    assign res_take = res_valid && res_ready;

    // track the walker state shown by the last word taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            prev_cnt_reg <= '0;
        end
        else if (res_take)
        begin
            prev_x_reg   <= res_x;
            prev_y_reg   <= res_y;
            prev_cnt_reg <= res_cnt;
        end
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_x) && $stable(res_y) && $stable(res_cnt))
        else $error("result word changed while stalled");

    a_refused_stays: assert property (@(posedge clk) disable iff (!rst_n)
        res_take && res_refused |->
            res_x == prev_x_reg && res_y == prev_y_reg
            && res_cnt == prev_cnt_reg + 1'b1)
        else $error("refused move changed position or miscounted");

    a_refused_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_take && res_refused |-> res_status != ST_MAPDONE)
        else $error("refusal reported on a map write");

endmodule

bind lattice_random_walk_step lrw_checker u_lrw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_x       (result.pos_x),
    .res_y       (result.pos_y),
    .res_cnt     (result.steps_taken),
    .res_status  (result.walk_status),
    .res_refused (result.move_refused)
);

`default_nettype wire
